// File: sv/scvu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvu_pkg: shared types and constants of the scrolling VU meter LED driver
// Holds the meter geometry, field widths, register indexes, the controller
// state type and the command and status structs between the modules.
// ----------------------------------------------------------------------------
package scvu_pkg;

  // Meter geometry.
  localparam int ROWS       = 9;
  localparam int COLUMNS    = 5;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int FRAME_LEDS = COLUMNS * (ROWS + 1) - 1;

  // Field widths.
  localparam int LVL_W  = 8;
  localparam int LED_W  = 6;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 2;

  // Internal widths.
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(FRAME_LEDS);
  localparam int V_W    = LVL_W + $clog2(ROWS + 1);

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] DECAY_RST  = 8'd5;
  localparam logic [CFG_W-1:0] THRESH_RST = 8'd10;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_DECAY  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_THRESH = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;  // take the input level, decay and scroll
    logic fill;    // write one row of column 0
    logic issue;   // start the read of one LED of the frame
  } cmd_t;

  typedef struct packed {
    logic fill_last;  // the top row of column 0 is being written
    logic emit_last;  // the final LED of the frame is being issued
    logic advance;    // the read stage may move into the output register
  } sts_t;

endpackage

// File: sv/scvu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvu_ctrl: sequencer of the VU meter driver
// Steps each item through acceptance, the column fill and the frame readout.
// ----------------------------------------------------------------------------
module scvu_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output scvu_pkg::cmd_t cmd,
  input  scvu_pkg::sts_t sts
);
  import scvu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts.fill_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.advance && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.fill   = 1'b0;
    cmd.issue  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
      end
      ST_EMIT: begin
        cmd.issue = sts.advance;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: sv/scvu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvu_datapath: level processing, cell memory and frame output
// Holds the configuration, the decayed level, the scroll state, the cell
// memory addressed through a rotating column pointer, and the output stage.
// ----------------------------------------------------------------------------
module scvu_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [scvu_pkg::CIDX_W-1:0] cfg_index,
  input  logic [scvu_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [scvu_pkg::LVL_W-1:0]  in_level,
  input  scvu_pkg::cmd_t              cmd,
  output scvu_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scvu_pkg::LED_W-1:0]  out_led_index,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        out_last_led
);
  import scvu_pkg::*;

  // Configuration.
  logic [CFG_W-1:0] decay_r, thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= DECAY_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DECAY:  decay_r  <= cfg_wdata;
        REG_THRESH: thresh_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Level decay, scroll and column head.
  logic [LVL_W-1:0]   prev_r, lvl_nxt, drop;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [COL_W-1:0]   head_r, head_nxt;
  logic [COLUMNS-1:0] lit_r, lit_nxt;
  logic [V_W-1:0]     v_r, v_nxt, part;
  logic [ROW_W-1:0]   frow_r;
  logic               scroll;

  assign drop    = prev_r - decay_r;
  assign lvl_nxt = (prev_r >= decay_r && in_level < drop) ? drop : in_level;
  assign scroll  = (cnt_r >= thresh_r);

  always_comb begin
    cnt_nxt  = cnt_r + 8'd1;
    head_nxt = head_r;
    lit_nxt  = lit_r | COLUMNS'(1);
    if (scroll) begin
      cnt_nxt  = '0;
      head_nxt = (head_r == '0) ? COL_W'(COLUMNS - 1) : head_r - COL_W'(1);
      lit_nxt  = {lit_r[COLUMNS-2:0], 1'b1};
    end
  end

  assign part  = (v_r < V_W'(255)) ? v_r : V_W'(255);
  assign v_nxt = v_r - part;
  assign sts.fill_last = (frow_r == ROW_W'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      cnt_r  <= '0;
      head_r <= '0;
      lit_r  <= '0;
      frow_r <= '0;
    end else if (cmd.accept) begin
      prev_r <= lvl_nxt;
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      lit_r  <= lit_nxt;
      frow_r <= '0;
    end else if (cmd.fill) begin
      frow_r <= sts.fill_last ? '0 : frow_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_r <= V_W'(lvl_nxt) * V_W'(ROWS);
    end else if (cmd.fill) begin
      v_r <= v_nxt;
    end
  end

  // Frame scan counters.
  logic [IDX_W-1:0] idx_r;
  logic [COL_W-1:0] col_r;
  logic [POS_W-1:0] pos_r;

  assign sts.emit_last = (idx_r == IDX_W'(FRAME_LEDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      col_r <= '0;
      pos_r <= '0;
    end else if (cmd.issue) begin
      if (sts.emit_last) begin
        idx_r <= '0;
        col_r <= '0;
        pos_r <= '0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
        if (pos_r == POS_W'(ROWS)) begin
          pos_r <= '0;
          col_r <= col_r + COL_W'(1);
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  // Cell memory: the logical column is mapped through the rotating head.
  logic [COL_W:0]    col_sum;
  logic [COL_W-1:0]  wcol, rcol;
  logic [ROW_W-1:0]  rrow;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              rlit;
  logic [7:0]        cell_mem [CELLS];
  logic [7:0]        rdata_r;

  assign col_sum = {1'b0, head_r} + {1'b0, col_r};
  assign rcol    = (col_sum >= (COL_W + 1)'(COLUMNS)) ?
                   COL_W'(col_sum - (COL_W + 1)'(COLUMNS)) : COL_W'(col_sum);
  assign rrow    = col_r[0] ? (ROW_W'(ROWS - 1) - ROW_W'(pos_r)) : ROW_W'(pos_r);
  assign raddr   = ADDR_W'(rcol) * ADDR_W'(ROWS) + ADDR_W'(rrow);
  assign wcol    = head_r;
  assign waddr   = ADDR_W'(wcol) * ADDR_W'(ROWS) + ADDR_W'(frow_r);
  assign rlit    = (pos_r < POS_W'(ROWS)) && lit_r[col_r];

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      cell_mem[waddr] <= part[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata_r <= cell_mem[raddr];
    end
  end

  // Read stage and output register.
  logic             s1_valid_r, s1_lit_r, s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             out_valid_r, out_last_r;
  logic [LED_W-1:0] out_idx_r;
  logic [7:0]       out_red_r, out_gb_r;

  assign sts.advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (sts.advance) begin
      s1_valid_r  <= cmd.issue;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_lit_r  <= rlit;
      s1_last_r <= sts.emit_last;
      s1_idx_r  <= idx_r;
    end
    if (sts.advance && s1_valid_r) begin
      out_idx_r  <= LED_W'(s1_idx_r);
      out_last_r <= s1_last_r;
      out_red_r  <= s1_lit_r ? 8'd255 : 8'd0;
      out_gb_r   <= s1_lit_r ? rdata_r : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = out_idx_r;
  assign out_red       = out_red_r;
  assign out_green     = out_gb_r;
  assign out_blue      = out_gb_r;
  assign out_last_led  = out_last_r;

endmodule

// File: sv/scrolling_vu_meter_led_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_vu_meter_led_driver: LED VU meter with decay and scrolling history
//
//   Port group   Direction  Transfer when           Contents
//   in_*         input      in_valid & !in_stall    one level byte
//   out_*        output     out_valid & !out_stall  one LED of the frame
//   cfg_*        input      cfg_wr_en               decay limit, shift threshold
//
// Each accepted level is taken in, its ROWS (9) rows are written into column 0
// of the cell memory, and the frame's 49 LEDs are then read out in chain order.
// The sequencer does the fill and the readout in turn, never both at once.
// A stall on the output holds the read stage and the scan; the next level is
// accepted once the last LED has been read, while the final LEDs still drain.
// Reset (rst_n low, synchronous) restores the register defaults and blanks all
// columns; the cell memory itself is not cleared, since unlit columns show black.
// ----------------------------------------------------------------------------
module scrolling_vu_meter_led_driver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [scvu_pkg::CIDX_W-1:0] cfg_index,
  input  logic [scvu_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [scvu_pkg::LVL_W-1:0]  in_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scvu_pkg::LED_W-1:0]  out_led_index,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        out_last_led
);
  import scvu_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  scvu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath owns the configuration, the level history and the output
  // register that decouples the readout from the downstream stall.
  scvu_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_level      (in_level),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_led  (out_last_led)
  );

endmodule

// File: tb/scrolling_vu_meter_led_driver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_vu_meter_led_driver_test: self-checking bench for the VU meter
// Feeds level bytes through the valid/stall input and runs a model of the
// decay, scroll and bar fill. The model predicts every LED of each serpentine
// frame, and a checker compares the LED transfers field by field. The bench
// also writes the decay and scroll registers between phases and stalls the
// output at random and for one long stretch.
// ----------------------------------------------------------------------------
module scrolling_vu_meter_led_driver_test;
  import scvu_pkg::*;

  // Indexes that decode to no register; writes to them must be dropped.
  localparam logic [CIDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int SETTLE_CYCLES   = 80;    // more than one frame time
  localparam int HOLD_OFF_CYCLES = 400;   // long output stall under pressure
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any transfer

  // One LED of a frame as it should appear on the out_* ports.
  typedef struct packed {
    logic [LED_W-1:0] led_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_led;
  } led_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [LVL_W-1:0]   in_level;
  logic               out_valid;
  logic               out_stall;
  logic [LED_W-1:0]   out_led_index;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               out_last_led;

  // Model state: register copies, the decay and scroll state, and the cells.
  logic [7:0] decay_lim;
  logic [7:0] scroll_at;
  logic [7:0] prev_level;
  logic [7:0] sample_cnt;
  logic [7:0] cell_lvl [CELLS];
  logic       col_lit [COLUMNS];

  led_t pending_leds[$];   // LEDs predicted but not yet seen on the output

  int idle_pct;            // chance in a hundred that either side idles
  bit hold_off_pending;    // asks the output side for one long stall
  int mismatches;
  int levels_sent;
  int leds_checked;
  int scrolls;

  scrolling_vu_meter_led_driver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_level      (in_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_led  (out_last_led)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the meter model by one accepted level and queues the full frame
  // of LEDs it should produce, in chain order.
  task automatic predict_frame(input logic [7:0] raw);
    logic [7:0]  shown;
    int unsigned bar;
    int unsigned part;
    int          idx;
    int          pos;
    int          col;
    int          row;
    led_t        led;
    shown = raw;
    // A falling level may only drop by the decay limit. When the limit is
    // larger than the previous level, the new level is taken as it is.
    if (raw < prev_level && prev_level >= decay_lim && raw < prev_level - decay_lim)
      shown = prev_level - decay_lim;
    prev_level = shown;
    // Scroll the history right once the count reaches the threshold.
    if (sample_cnt >= scroll_at) begin
      sample_cnt = '0;
      scrolls++;
      for (col = COLUMNS - 1; col > 0; col--) begin
        for (row = 0; row < ROWS; row++)
          cell_lvl[col * ROWS + row] = cell_lvl[(col - 1) * ROWS + row];
        col_lit[col] = col_lit[col - 1];
      end
    end else begin
      sample_cnt = sample_cnt + 8'd1;
    end
    // Column 0 becomes a bar: each row soaks up at most 255 of level*ROWS.
    bar = shown * ROWS;
    for (row = 0; row < ROWS; row++) begin
      part = (bar < 255) ? bar : 255;
      bar -= part;
      cell_lvl[row] = part[7:0];
    end
    col_lit[0] = 1'b1;
    // Serpentine chain: odd columns run top-down, and the LED after each
    // column's run of rows, but the final one, is an unused corner that stays black.
    for (idx = 0; idx < FRAME_LEDS; idx++) begin
      pos = idx % (ROWS + 1);
      col = idx / (ROWS + 1);
      led.led_index = idx[LED_W-1:0];
      led.red       = '0;
      led.green     = '0;
      led.blue      = '0;
      led.last_led  = (idx == FRAME_LEDS - 1);
      if (pos < ROWS && col < COLUMNS && col_lit[col]) begin
        row = (col % 2 == 1) ? (ROWS - 1 - pos) : pos;
        led.red   = 8'hFF;
        led.green = cell_lvl[col * ROWS + row];
        led.blue  = cell_lvl[col * ROWS + row];
      end
      pending_leds.push_back(led);
    end
  endtask

  // Offers one level and returns at the edge where it is transferred. The
  // valid stays high afterwards so that back-to-back levels have no gap.
  task automatic send_level(input logic [7:0] lvl);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_level <= lvl;
    do @(posedge clk); while (in_stall);
    levels_sent++;
    predict_frame(lvl);
  endtask

  // Stops offering levels, waits until every predicted LED has arrived, then
  // gives the block a frame time to settle before registers are touched.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Only called while the block is idle.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_DECAY:  decay_lim = val;
      REG_THRESH: scroll_at = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_setting();
    case ($urandom_range(4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(1, 6));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Default registers: a bar lit at level zero, a full bar, the decay limit
  // being larger than the previous level, decayed falls, rows that split a
  // level across the 255 boundary, and enough samples to scroll once so
  // that unlit columns and the corner LEDs show up in the frames.
  task automatic test_directed_levels();
    logic [7:0] levels [16];
    int         n;
    levels = '{8'd0, 8'd3, 8'd0, 8'd255, 8'd0, 8'd200, 8'd240, 8'd28,
               8'd29, 8'd57, 8'd128, 8'd127, 8'd254, 8'd1, 8'd170, 8'd85};
    for (n = 0; n < 16; n++)
      send_level(levels[n]);
  endtask

  // Each register at both extremes, a threshold lowered below the running
  // count, and writes to the spare indexes that must change nothing.
  task automatic test_register_settings();
    drain_and_settle();
    write_reg(REG_DECAY, 8'h00);        // the level can never fall
    send_level(8'd90);
    send_level(8'd10);
    drain_and_settle();
    write_reg(REG_DECAY, 8'hFF);        // any fall goes straight through
    write_reg(REG_THRESH, 8'h00);       // scroll on every sample
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd17);
    send_level(8'd0);
    send_level(8'd99);
    send_level(8'd200);
    drain_and_settle();
    write_reg(REG_THRESH, 8'd20);
    send_level(8'd60);
    send_level(8'd61);
    send_level(8'd62);
    drain_and_settle();
    write_reg(REG_THRESH, 8'd1);        // now below the count, so it scrolls
    write_reg(REG_SPARE_LO, 8'h00);
    write_reg(REG_SPARE_HI, 8'hFF);
    send_level(8'd63);
    send_level(8'd64);
    drain_and_settle();
    write_reg(REG_THRESH, 8'hFF);
    write_reg(REG_DECAY, 8'd5);
    send_level(8'd250);
    send_level(8'd0);
  endtask

  // Phases of random levels under random settings. Most levels follow an
  // envelope, so decay limits actually bite; the rest jump or pin at the
  // extremes. One phase runs with no idling on either side.
  task automatic test_random_levels();
    int         phase;
    int         n;
    int         roll;
    int         env;
    logic [7:0] lvl;
    env = 128;
    for (phase = 0; phase < 5; phase++) begin
      drain_and_settle();
      write_reg(REG_DECAY, pick_setting());
      write_reg(REG_THRESH, pick_setting());
      idle_pct = (phase == 2) ? 0 : 17;
      for (n = 0; n < 33; n++) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          env = env + $urandom_range(80) - 45;
          if (env < 0) env = 0;
          if (env > 255) env = 255;
        end else if (roll < 82) begin
          env = $urandom_range(255);
        end else if (roll < 91) begin
          env = 0;
        end else begin
          env = 255;
        end
        lvl = env[7:0];
        send_level(lvl);
      end
    end
    idle_pct = 17;
  endtask

  // The output side holds its stall for a long stretch while levels keep
  // coming, so the block has to stall its own input until the frame drains.
  task automatic test_output_hold_off();
    int n;
    drain_and_settle();
    idle_pct = 0;
    hold_off_pending = 1'b1;
    for (n = 0; n < 6; n++)
      send_level(8'($urandom_range(255)));
    idle_pct = 17;
  endtask

  // Output side: random stalls, or one long hold-off when asked for.
  initial begin : out_stall_driver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_off_pending = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Compares every LED transfer against the oldest predicted LED.
  initial begin : led_checker
    led_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        leds_checked++;
        if (pending_leds.size() == 0) begin
          $error("unexpected LED transfer: led_index %0d", out_led_index);
          mismatches++;
        end else begin
          want = pending_leds.pop_front();
          if (out_led_index !== want.led_index) begin
            $error("led_index: expected %0d, actual %0d", want.led_index, out_led_index);
            mismatches++;
          end
          if (out_red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_red);
            mismatches++;
          end
          if (out_green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_green);
            mismatches++;
          end
          if (out_blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_blue);
            mismatches++;
          end
          if (out_last_led !== want.last_led) begin
            $error("last_led: expected %0d, actual %0d", want.last_led, out_last_led);
            mismatches++;
          end
        end
      end
    end
  end

  // Ends a hung run: too many cycles in a row with no transfer on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : main
    int n;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_DECAY;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_level  <= '0;
    idle_pct         = 17;
    hold_off_pending = 1'b0;
    mismatches       = 0;
    levels_sent      = 0;
    leds_checked     = 0;
    scrolls          = 0;
    // Model state after reset: default registers, every column black.
    decay_lim  = DECAY_RST;
    scroll_at  = THRESH_RST;
    prev_level = '0;
    sample_cnt = '0;
    for (n = 0; n < CELLS; n++) cell_lvl[n] = '0;
    for (n = 0; n < COLUMNS; n++) col_lit[n] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_levels();
    test_register_settings();
    test_random_levels();
    test_output_hold_off();
    drain_and_settle();

    if (pending_leds.size() != 0) begin
      $error("%0d predicted LEDs never arrived", pending_leds.size());
      mismatches++;
    end
    $display("Covered %0d levels and %0d LED transfers with %0d history scrolls,",
             levels_sent, leds_checked, scrolls);
    $display("decay and threshold from 0 to 255, spare register writes and a long stall.");
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: scrolling_vu_meter_led_driver.f
sv/scvu_pkg.sv
sv/scvu_ctrl.sv
sv/scvu_datapath.sv
sv/scrolling_vu_meter_led_driver.sv
tb/scrolling_vu_meter_led_driver_test.sv
